### hw/rtl/pibfa_pkg.sv
// shared constants and types for the process image bit field store
`timescale 1ns / 1ps

package pibfa_pkg;

	localparam int IMAGE_DEPTH = 2048;
	localparam int WORD_BYTES = 8;
	localparam int WORD_COUNT = IMAGE_DEPTH / WORD_BYTES;
	localparam int BANK_DEPTH = WORD_COUNT / 2;
	localparam int WORD_AW = $clog2(WORD_COUNT);
	localparam int BANK_AW = WORD_AW - 1;

	localparam int SIZE_W = 12;
	localparam int BYTE_W = 11;
	localparam int BIT_W = 3;
	localparam int LEN_W = 7;
	localparam int VAL_W = 64;
	localparam int OFF_W = 6;
	localparam int WIN_W = 2 * VAL_W;
	localparam int WIN_BYTES = 2 * WORD_BYTES;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [LEN_W-1:0] MAX_LEN = 7'd64;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_READ = 1'b1;

	typedef struct packed {
		logic               is_read;
		logic               ok;
		logic [WORD_AW-1:0] word;
		logic [OFF_W-1:0]   off;
		logic [VAL_W-1:0]   mask;
		logic [VAL_W-1:0]   wval;
	} entry_t;

endpackage

### hw/rtl/pibfa_ifs.sv
// request, response and size register channels
`timescale 1ns / 1ps

interface pibfa_req_if;
	import pibfa_pkg::*;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic [BYTE_W-1:0]  start_byte;
	logic [BIT_W-1:0]   start_bit;
	logic [LEN_W-1:0]   field_len;
	logic [VAL_W-1:0]   write_value;
	modport source (output valid, output req_type, output start_byte, output start_bit,
		output field_len, output write_value, input ready);
	modport sink (input valid, input req_type, input start_byte, input start_bit,
		input field_len, input write_value, output ready);
endinterface

interface pibfa_rsp_if;
	import pibfa_pkg::*;
	logic              valid;
	logic              ready;
	logic [VAL_W-1:0]  read_value;
	logic              accepted;
	modport source (output valid, output read_value, output accepted, input ready);
	modport sink (input valid, input read_value, input accepted, output ready);
endinterface

interface pibfa_cfg_if;
	import pibfa_pkg::*;
	logic              valid;
	logic              ready;
	logic [SIZE_W-1:0] image_bytes;
	modport source (output valid, output image_bytes, input ready);
	modport sink (input valid, input image_bytes, output ready);
endinterface

### hw/rtl/process_image_bit_field_access_top.sv
// top level of the process image bit field store
//
// channels: req carries field write or read requests (type, start byte, start bit,
// length, value); rsp returns one response per request (read_value, accepted);
// cfg writes the image_bytes size register and is always ready.
// requests are checked and queued by the front end (two entries), then the back
// end reads the two 64-bit words the field spans from an even and an odd bank,
// extracts or inserts the field and writes the words back.
// a request passes through the queue and the back end stage register before the
// response register takes its result; the back end takes a new request only after
// the previous one has finished its read-modify-write on the store banks.
// reset clears the size register and the per-word valid bits, so the whole store
// reads zero at once with no clearing pass; every request is rejected until the
// size is written. change the size only while no request is in flight.
// when rsp stalls the response register holds, the back end holds its request,
// the queue fills and req.ready drops.
`timescale 1ns / 1ps

module process_image_bit_field_access_top (
	input  logic        clk,
	input  logic        arst_n,
	pibfa_req_if.sink   req,
	pibfa_rsp_if.source rsp,
	pibfa_cfg_if.sink   cfg
);
	import pibfa_pkg::*;

	logic [SIZE_W-1:0] image_bytes_q;
	logic [SIZE_W-1:0] size_eff;
	logic              q_full;
	logic              q_empty;
	logic              push;
	logic              pop;
	entry_t            push_entry;
	entry_t            head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_bytes_q <= '0;
		end else if (cfg.valid) begin
			image_bytes_q <= cfg.image_bytes;
		end
	end

	assign cfg.ready = 1'b1;
	assign size_eff = (image_bytes_q > SIZE_W'(IMAGE_DEPTH)) ? SIZE_W'(IMAGE_DEPTH)
		: image_bytes_q;

	pibfa_front u_front (
		.req    (req),
		.size   (size_eff),
		.q_full (q_full),
		.push   (push),
		.entry  (push_entry)
	);

	pibfa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.empty      (q_empty)
	);

	pibfa_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.size    (size_eff),
		.head    (head),
		.q_empty (q_empty),
		.pop     (pop),
		.rsp     (rsp)
	);

endmodule

### hw/rtl/pibfa_front.sv
// front end: takes requests and classifies them into queue entries
`timescale 1ns / 1ps

module pibfa_front (
	pibfa_req_if.sink                    req,
	input  logic [pibfa_pkg::SIZE_W-1:0] size,
	input  logic                         q_full,
	output logic                         push,
	output pibfa_pkg::entry_t            entry
);
	import pibfa_pkg::*;

	logic [LEN_W-1:0] len_c;
	logic [VAL_W-1:0] mask;

	always_comb begin
		len_c = (req.field_len > MAX_LEN) ? MAX_LEN : req.field_len;
		if (len_c == MAX_LEN) begin
			mask = '1;
		end else begin
			mask = (VAL_W'(1) << len_c) - VAL_W'(1);
		end
		entry.is_read = (req.req_type == REQ_READ);
		entry.ok = (req.field_len != '0) && ({1'b0, req.start_byte} < size);
		entry.word = req.start_byte[BYTE_W-1:BIT_W];
		entry.off = {req.start_byte[BIT_W-1:0], req.start_bit};
		entry.mask = mask;
		entry.wval = req.write_value & mask;
	end

	assign req.ready = !q_full;
	assign push = req.valid && !q_full;

endmodule

### hw/rtl/pibfa_queue.sv
// short queue between front and back end
`timescale 1ns / 1ps

module pibfa_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pibfa_pkg::entry_t push_entry,
	output logic              full,
	input  logic              pop,
	output pibfa_pkg::entry_t head,
	output logic              empty
);
	import pibfa_pkg::*;

	entry_t            slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	assign head = slot_q[rd_ptr_q];
	assign full = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);

endmodule

### hw/rtl/pibfa_back.sv
// back end: banked image store, read-modify-write of the two words a field spans
`timescale 1ns / 1ps

module pibfa_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [pibfa_pkg::SIZE_W-1:0] size,
	input  pibfa_pkg::entry_t            head,
	input  logic                         q_empty,
	output logic                         pop,
	pibfa_rsp_if.source                  rsp
);
	import pibfa_pkg::*;

	logic [VAL_W-1:0]      mem_even [BANK_DEPTH];
	logic [VAL_W-1:0]      mem_odd [BANK_DEPTH];
	logic [BANK_DEPTH-1:0] vld_even_q;
	logic [BANK_DEPTH-1:0] vld_odd_q;

	logic [BANK_AW-1:0] even_addr;
	logic [BANK_AW-1:0] odd_addr;

	logic               busy_s1;
	entry_t             entry_s1;
	logic [BANK_AW-1:0] even_addr_s1;
	logic [BANK_AW-1:0] odd_addr_s1;
	logic [VAL_W-1:0]   rd_even_s1;
	logic [VAL_W-1:0]   rd_odd_s1;
	logic               vld_even_s1;
	logic               vld_odd_s1;

	logic               rsp_valid_q;
	logic [VAL_W-1:0]   read_value_q;
	logic               accepted_q;

	logic               done;
	logic               wr_en;
	logic [VAL_W-1:0]   even_word;
	logic [VAL_W-1:0]   odd_word;
	logic [WIN_W-1:0]   win;
	logic [WIN_W-1:0]   bit_ok;
	logic [WIN_W-1:0]   fmask;
	logic [WIN_W-1:0]   new_win;
	logic [WIN_W-1:0]   rd_shift;
	logic [SIZE_W-1:0]  byte_addr;
	logic [VAL_W-1:0]   rval;
	logic [VAL_W-1:0]   new_even;
	logic [VAL_W-1:0]   new_odd;

	// odd start word: low half from the odd bank, high half from the next even word
	assign odd_addr = head.word[WORD_AW-1:1];
	assign even_addr = head.word[0] ? (head.word[WORD_AW-1:1] + BANK_AW'(1))
		: head.word[WORD_AW-1:1];

	assign pop = !q_empty && !busy_s1;
	assign done = busy_s1 && (!rsp_valid_q || rsp.ready);
	assign wr_en = done && entry_s1.ok && !entry_s1.is_read;

	always_comb begin
		even_word = vld_even_s1 ? rd_even_s1 : '0;
		odd_word = vld_odd_s1 ? rd_odd_s1 : '0;
		win = entry_s1.word[0] ? {even_word, odd_word} : {odd_word, even_word};
		for (int i = 0; i < WIN_BYTES; i++) begin
			byte_addr = {1'b0, entry_s1.word, BIT_W'(0)} + SIZE_W'(i);
			bit_ok[i*8 +: 8] = {8{byte_addr < size}};
		end
		fmask = ({{VAL_W{1'b0}}, entry_s1.mask} << entry_s1.off) & bit_ok;
		new_win = (win & ~fmask)
			| (({{VAL_W{1'b0}}, entry_s1.wval} << entry_s1.off) & fmask);
		rd_shift = (win & bit_ok) >> entry_s1.off;
		rval = rd_shift[VAL_W-1:0] & entry_s1.mask;
		new_even = entry_s1.word[0] ? new_win[WIN_W-1:VAL_W] : new_win[VAL_W-1:0];
		new_odd = entry_s1.word[0] ? new_win[VAL_W-1:0] : new_win[WIN_W-1:VAL_W];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rd_even_s1 <= mem_even[even_addr];
			rd_odd_s1 <= mem_odd[odd_addr];
		end
		if (wr_en) begin
			mem_even[even_addr_s1] <= new_even;
			mem_odd[odd_addr_s1] <= new_odd;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			entry_s1 <= head;
			even_addr_s1 <= even_addr;
			odd_addr_s1 <= odd_addr;
		end
		if (done) begin
			read_value_q <= (entry_s1.ok && entry_s1.is_read) ? rval : '0;
			accepted_q <= entry_s1.ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_even_q <= '0;
			vld_odd_q <= '0;
			vld_even_s1 <= 1'b0;
			vld_odd_s1 <= 1'b0;
			busy_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				vld_even_s1 <= vld_even_q[even_addr];
				vld_odd_s1 <= vld_odd_q[odd_addr];
			end
			if (wr_en) begin
				vld_even_q[even_addr_s1] <= 1'b1;
				vld_odd_q[odd_addr_s1] <= 1'b1;
			end
			if (pop) begin
				busy_s1 <= 1'b1;
			end else if (done) begin
				busy_s1 <= 1'b0;
			end
			if (done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.read_value = read_value_q;
	assign rsp.accepted = accepted_q;

endmodule

### hw/rtl/pibfa_checker.sv
// port-level checks on the top level, attached by bind
`timescale 1ns / 1ps

module pibfa_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic                        rsp_accepted,
	input logic [pibfa_pkg::VAL_W-1:0] rsp_read_value
);
	import pibfa_pkg::*;

	localparam int MAX_OUT = QUEUE_DEPTH + 2;
	localparam int OUT_W = $clog2(MAX_OUT + 1);

	logic [OUT_W-1:0] outstanding_q;
	logic             req_acc;
	logic             rsp_acc;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else if (req_acc && !rsp_acc) begin
			outstanding_q <= outstanding_q + OUT_W'(1);
		end else if (rsp_acc && !req_acc) begin
			outstanding_q <= outstanding_q - OUT_W'(1);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_accepted |-> rsp_read_value == '0)
		else $error("rejected request returned nonzero data");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> outstanding_q != '0)
		else $error("response without a pending request");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q == OUT_W'(MAX_OUT) |-> !req_ready)
		else $error("request taken with all slots in use");

endmodule

bind process_image_bit_field_access_top pibfa_checker u_pibfa_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_accepted   (rsp.accepted),
	.rsp_read_value (rsp.read_value)
);
